[rtl/core/bmbn_pkg.sv]
package bmbn_pkg;

	// Default frame limits; the top level takes them as parameters.
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 128;

	// Field and state widths.
	localparam int VAL_W      = 16;
	localparam int IW_W       = 11;
	localparam int IH_W       = 8;
	localparam int WW_W       = 11;
	localparam int WH_W       = 8;
	localparam int QX_W       = 10;
	localparam int QY_W       = 7;
	localparam int SUM_W      = 33;
	localparam int CNT_W      = 18;
	localparam int RSUM_W     = 26;
	localparam int RCNT_W     = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Shared divider sizing: a signed window sum over two boxes, a count divisor.
	localparam int DIV_N_W = SUM_W + 3;
	localparam int DIV_D_W = CNT_W + 2;
	localparam int DIV_Q_W = 16;

	// Q8.8 constants.
	localparam int ONE_Q88  = 256;
	localparam int NORM_MAX = 65280;
	localparam int MEAN_MAX = 65535;

	// Register reset values.
	localparam int IMAGE_WIDTH_RST  = 1024;
	localparam int IMAGE_HEIGHT_RST = 128;
	localparam int WINDOW_WIDTH_RST = 9;
	localparam int WINDOW_HEIGHT_RST = 7;
	localparam int SCALE_RST        = 256;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_RSVD  = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH   = 3'd0,
		CFG_IMAGE_HEIGHT  = 3'd1,
		CFG_WINDOW_WIDTH  = 3'd2,
		CFG_WINDOW_HEIGHT = 3'd3,
		CFG_SCALE         = 3'd4
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LD_RD,
		S_LD_WR,
		S_Q_XMOD,
		S_Q_XWAIT,
		S_Q_SETUP,
		S_Q_RD,
		S_Q_ACC,
		S_Q_MEAN,
		S_Q_MWAIT,
		S_Q_MUL,
		S_Q_NORM,
		S_Q_NWAIT,
		S_Q_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]       command;
		logic [VAL_W-1:0] pixel_value;
		logic             occupied;
		logic [QX_W-1:0]  query_x;
		logic [QY_W-1:0]  query_y;
		logic [VAL_W-1:0] point_value;
	} in_t;

	typedef struct packed {
		logic [VAL_W-1:0] normalized_value;
		logic [VAL_W-1:0] window_mean;
	} out_t;

endpackage

[rtl/core/bmbn_ram.sv]
module bmbn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/bmbn_div.sv]
module bmbn_div #(
	parameter int N_W = bmbn_pkg::DIV_N_W,
	parameter int D_W = bmbn_pkg::DIV_D_W,
	parameter int Q_W = bmbn_pkg::DIV_Q_W
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic           busy,
	output logic [Q_W-1:0] quotient,
	output logic [D_W-1:0] remainder
);

	// Restoring division, one quotient bit per cycle. The caller guarantees
	// that the quotient fits in Q_W bits.
	localparam int SH_W  = D_W + Q_W - 1;
	localparam int CMP_W = (N_W > SH_W) ? N_W : SH_W;
	localparam int CT_W  = $clog2(Q_W + 1);

	logic [N_W-1:0]  rem_q;
	logic [SH_W-1:0] den_q;
	logic [Q_W-1:0]  quo_q;
	logic [CT_W-1:0] cnt_q;
	logic [CMP_W:0]  diff;
	logic            ge;

	assign diff = {1'b0, CMP_W'(rem_q)} - {1'b0, CMP_W'(den_q)};
	assign ge   = !diff[CMP_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CT_W'(Q_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			den_q <= SH_W'(divisor) << (Q_W - 1);
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			if (ge) begin
				rem_q <= N_W'(diff[CMP_W-1:0]);
			end
			quo_q <= {quo_q[Q_W-2:0], ge};
			den_q <= den_q >> 1;
		end
	end

	assign busy      = (cnt_q != '0);
	assign quotient  = quo_q;
	assign remainder = rem_q[D_W-1:0];

endmodule

[rtl/core/box_mean_brightness_normalizer_core.sv]
// Box-mean brightness normalizer. A frame is loaded pixel by pixel in raster
// order; each load builds one entry of two integral images (brightness sum of
// occupied pixels and occupied count), kept together in a single synchronous
// RAM of (MAX_WIDTH+1)*(MAX_HEIGHT+1) entries with a fixed row stride of
// MAX_WIDTH+1. Row zero and column zero of the tables are never stored; the
// read path returns zero for them, so no clearing pass is needed after reset.
// A query reads four corners per box (eight when the window wraps around the
// right image edge), divides sum by count for the window mean, and returns
// floor(scale * point_value / (mean + 1.0)) saturated at 255.0, both in Q8.8.
// The block works on one item at a time. A load goes through the accept, a
// RAM read of the entry above and the write back. A query whose window does
// not wrap and whose query_x lies inside the image goes through the accept,
// a setup step, four corner reads through the single RAM read port, an
// accumulate step, the mean decision, a wait on the shared restoring divider
// for the mean, the multiply, the normalization decision, a second divider
// wait, and the output step. A window that wraps reads four more corners. A
// query_x at or beyond the image width adds the column wrap (a divider start
// and a divider wait), and an empty or saturated window mean, or a saturated
// result, skips its divider wait. Start-frame commands are taken without
// leaving the idle state; command 3 is dropped. The finished result sits in
// an output register, so the next item is accepted while it waits for a
// transfer; a second query then holds in its output state until that
// transfer. Configuration writes are accepted every cycle and must only be
// issued while the block is idle.
module box_mean_brightness_normalizer_core #(
	parameter int MAX_WIDTH  = bmbn_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bmbn_pkg::MAX_HEIGHT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  bmbn_pkg::in_t                       in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output bmbn_pkg::out_t                      out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bmbn_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bmbn_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int STRIDE = MAX_WIDTH + 1;
	localparam int DEPTH  = STRIDE * (MAX_HEIGHT + 1);
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int COL_W  = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
	localparam int ENT_W  = bmbn_pkg::SUM_W + bmbn_pkg::CNT_W;
	localparam int XW     = ((COL_W > bmbn_pkg::WW_W) ? COL_W : bmbn_pkg::WW_W) + 2;
	localparam int YW     = ((ROW_W > bmbn_pkg::WH_W) ? ROW_W : bmbn_pkg::WH_W) + 2;
	localparam int N_W    = bmbn_pkg::DIV_N_W;
	localparam int D_W    = bmbn_pkg::DIV_D_W;
	localparam int Q_W    = bmbn_pkg::DIV_Q_W;
	localparam int VAL_W  = bmbn_pkg::VAL_W;
	localparam int PROD_W = 2 * VAL_W;
	localparam int LIM_W  = VAL_W + 1 + VAL_W + 1;

	// Configuration registers.
	logic [bmbn_pkg::IW_W-1:0]  iw_q;
	logic [bmbn_pkg::IH_W-1:0]  ih_q;
	logic [bmbn_pkg::WW_W-1:0]  ww_q;
	logic [bmbn_pkg::WH_W-1:0]  wh_q;
	logic [VAL_W-1:0]           scale_q;

	bmbn_pkg::state_t state_q, state_d;

	// Frame loading state.
	logic [COL_W-1:0]              ld_col_q;
	logic [ROW_W-1:0]              ld_row_q;
	logic [bmbn_pkg::RSUM_W-1:0]   rsum_q;
	logic [bmbn_pkg::RCNT_W-1:0]   rcnt_q;
	logic [ADDR_W-1:0]             ld_addr_q;
	logic                          ld_top_q;
	logic [VAL_W-1:0]              pix_q;
	logic                          occ_q;

	// Query state.
	logic [bmbn_pkg::QX_W-1:0]     qx_q;
	logic [bmbn_pkg::QY_W-1:0]     qy_q;
	logic [VAL_W-1:0]              pt_q;
	logic [COL_W-1:0]              xm_q;
	logic [ROW_W-1:0]              y0_q, y1_q;
	logic [COL_W-1:0]              xa0_q, xa1_q, xb1_q;
	logic                          has_b_q;
	logic [2:0]                    k_q;
	logic                          rd_vld_s1, rd_neg_s1, rd_zero_s1;
	logic signed [N_W-1:0]         acc_s_q;
	logic signed [D_W:0]           acc_c_q;
	logic [VAL_W-1:0]              mean_q;
	logic [VAL_W-1:0]              norm_q;
	logic [PROD_W-1:0]             prod_q;
	logic [LIM_W-1:0]              lim_q;

	logic                          out_valid_q;
	bmbn_pkg::out_t                out_q;

	// Effective image size.
	logic [COL_W-1:0] ew;
	logic [ROW_W-1:0] eh;

	always_comb begin
		if (iw_q == '0) begin
			ew = COL_W'(1);
		end else if (32'(iw_q) > MAX_WIDTH) begin
			ew = COL_W'(MAX_WIDTH);
		end else begin
			ew = COL_W'(iw_q);
		end
		if (ih_q == '0) begin
			eh = ROW_W'(1);
		end else if (32'(ih_q) > MAX_HEIGHT) begin
			eh = ROW_W'(MAX_HEIGHT);
		end else begin
			eh = ROW_W'(ih_q);
		end
	end

	// Configuration writes.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iw_q    <= bmbn_pkg::IW_W'(bmbn_pkg::IMAGE_WIDTH_RST);
			ih_q    <= bmbn_pkg::IH_W'(bmbn_pkg::IMAGE_HEIGHT_RST);
			ww_q    <= bmbn_pkg::WW_W'(bmbn_pkg::WINDOW_WIDTH_RST);
			wh_q    <= bmbn_pkg::WH_W'(bmbn_pkg::WINDOW_HEIGHT_RST);
			scale_q <= VAL_W'(bmbn_pkg::SCALE_RST);
		end else if (cfg_valid) begin
			case (cfg_index)
				bmbn_pkg::CFG_IMAGE_WIDTH:   iw_q    <= cfg_data[bmbn_pkg::IW_W-1:0];
				bmbn_pkg::CFG_IMAGE_HEIGHT:  ih_q    <= cfg_data[bmbn_pkg::IH_W-1:0];
				bmbn_pkg::CFG_WINDOW_WIDTH:  ww_q    <= cfg_data[bmbn_pkg::WW_W-1:0];
				bmbn_pkg::CFG_WINDOW_HEIGHT: wh_q    <= cfg_data[bmbn_pkg::WH_W-1:0];
				bmbn_pkg::CFG_SCALE:         scale_q <= cfg_data[VAL_W-1:0];
				default: ;
			endcase
		end
	end

	// Table RAM: each entry holds {sum, count}.
	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [ENT_W-1:0]  ram_wdata, ram_rdata;

	bmbn_ram #(
		.WIDTH(ENT_W),
		.DEPTH(DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	logic [bmbn_pkg::SUM_W-1:0] rd_sum;
	logic [bmbn_pkg::CNT_W-1:0] rd_cnt;

	assign rd_sum = ram_rdata[ENT_W-1:bmbn_pkg::CNT_W];
	assign rd_cnt = ram_rdata[bmbn_pkg::CNT_W-1:0];

	// Shared divider.
	logic           div_start, div_busy;
	logic [N_W-1:0] div_n;
	logic [D_W-1:0] div_d;
	logic [Q_W-1:0] div_q;
	logic [D_W-1:0] div_r;

	bmbn_div #(
		.N_W(N_W),
		.D_W(D_W),
		.Q_W(Q_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_n),
		.divisor   (div_d),
		.busy      (div_busy),
		.quotient  (div_q),
		.remainder (div_r)
	);

	// Load path arithmetic: the entry written is the one above plus the row
	// prefix including the current pixel.
	logic [bmbn_pkg::RSUM_W-1:0] rsum_new;
	logic [bmbn_pkg::RCNT_W-1:0] rcnt_new;
	logic [bmbn_pkg::SUM_W-1:0]  prev_sum;
	logic [bmbn_pkg::CNT_W-1:0]  prev_cnt;
	logic                        col_last;
	logic                        ld_skip;

	assign rsum_new = occ_q ? rsum_q + bmbn_pkg::RSUM_W'(pix_q) : rsum_q;
	assign rcnt_new = occ_q ? rcnt_q + bmbn_pkg::RCNT_W'(1) : rcnt_q;
	assign prev_sum = ld_top_q ? '0 : rd_sum;
	assign prev_cnt = ld_top_q ? '0 : rd_cnt;
	assign col_last = (ld_col_q + COL_W'(1)) >= ew;
	assign ld_skip  = (ld_row_q >= eh) || (ld_col_q >= ew);

	// Corner selection: bit 2 picks the wrapped box, bit 1 the top row,
	// bit 0 the left column. Top-left and bottom-right corners add.
	logic [ROW_W-1:0]  c_row;
	logic [COL_W-1:0]  c_col;
	logic [ADDR_W-1:0] c_addr;
	logic [2:0]        last_k;

	always_comb begin
		c_row = k_q[1] ? y0_q : y1_q;
		if (k_q[2]) begin
			c_col = k_q[0] ? '0 : xb1_q;
		end else begin
			c_col = k_q[0] ? xa0_q : xa1_q;
		end
		c_addr = ADDR_W'(c_row) * ADDR_W'(STRIDE) + ADDR_W'(c_col);
		last_k = has_b_q ? 3'd7 : 3'd3;
	end

	// Window bounds from the wrapped column and clamped row.
	logic signed [XW-1:0] x_start, x_end, x_w, x_ww;
	logic                 x_full;
	logic signed [YW-1:0] y_c, y_lo, y_hi, y_h, y_hh;

	always_comb begin
		x_w    = XW'(ew);
		x_ww   = XW'(ww_q);
		x_full = x_ww >= x_w;
		x_start = XW'(xm_q) - XW'(ww_q[bmbn_pkg::WW_W-1:1]);
		if (x_start < 0) begin
			x_start = x_start + x_w;
		end
		x_end = x_start + x_ww;
		y_h   = YW'(eh);
		y_hh  = YW'(wh_q[bmbn_pkg::WH_W-1:1]);
		y_c   = (YW'(qy_q) >= y_h) ? y_h - YW'(1) : YW'(qy_q);
		y_lo  = y_c - y_hh;
		if (y_lo < 0) begin
			y_lo = '0;
		end
		y_hi = y_c + y_hh + YW'(1);
		if (y_hi > y_h) begin
			y_hi = y_h;
		end
	end

	// Window mean decisions. An empty window or a negative sum gives a zero mean.
	logic mean_zero, mean_sat, norm_sat;

	assign mean_zero = (acc_c_q <= 0) || (acc_s_q < 0);
	assign mean_sat  = (64'(acc_s_q) >= (64'(acc_c_q[D_W-1:0]) << Q_W)) && !acc_s_q[N_W-1];
	assign norm_sat  = (LIM_W'(prod_q) >= lim_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			bmbn_pkg::S_IDLE: begin
				if (in_valid) begin
					case (in_data.command)
						bmbn_pkg::CMD_LOAD: begin
							if (!ld_skip) begin
								state_d = bmbn_pkg::S_LD_RD;
							end
						end
						bmbn_pkg::CMD_QUERY: begin
							if (32'(in_data.query_x) < 32'(ew)) begin
								state_d = bmbn_pkg::S_Q_SETUP;
							end else begin
								state_d = bmbn_pkg::S_Q_XMOD;
							end
						end
						default: ;
					endcase
				end
			end
			bmbn_pkg::S_LD_RD:   state_d = bmbn_pkg::S_LD_WR;
			bmbn_pkg::S_LD_WR:   state_d = bmbn_pkg::S_IDLE;
			bmbn_pkg::S_Q_XMOD:  state_d = bmbn_pkg::S_Q_XWAIT;
			bmbn_pkg::S_Q_XWAIT: begin
				if (!div_busy) begin
					state_d = bmbn_pkg::S_Q_SETUP;
				end
			end
			bmbn_pkg::S_Q_SETUP: state_d = bmbn_pkg::S_Q_RD;
			bmbn_pkg::S_Q_RD: begin
				if (k_q == last_k) begin
					state_d = bmbn_pkg::S_Q_ACC;
				end
			end
			bmbn_pkg::S_Q_ACC:   state_d = bmbn_pkg::S_Q_MEAN;
			bmbn_pkg::S_Q_MEAN: begin
				if (mean_zero || mean_sat) begin
					state_d = bmbn_pkg::S_Q_MUL;
				end else begin
					state_d = bmbn_pkg::S_Q_MWAIT;
				end
			end
			bmbn_pkg::S_Q_MWAIT: begin
				if (!div_busy) begin
					state_d = bmbn_pkg::S_Q_MUL;
				end
			end
			bmbn_pkg::S_Q_MUL:   state_d = bmbn_pkg::S_Q_NORM;
			bmbn_pkg::S_Q_NORM: begin
				if (norm_sat) begin
					state_d = bmbn_pkg::S_Q_OUT;
				end else begin
					state_d = bmbn_pkg::S_Q_NWAIT;
				end
			end
			bmbn_pkg::S_Q_NWAIT: begin
				if (!div_busy) begin
					state_d = bmbn_pkg::S_Q_OUT;
				end
			end
			bmbn_pkg::S_Q_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_d = bmbn_pkg::S_IDLE;
				end
			end
			default: state_d = bmbn_pkg::S_IDLE;
		endcase
	end

	// State outputs: RAM port and divider controls.
	always_comb begin
		in_ready  = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = c_addr;
		ram_we    = 1'b0;
		ram_waddr = ld_addr_q + ADDR_W'(STRIDE);
		ram_wdata = {prev_sum + bmbn_pkg::SUM_W'(rsum_new),
		             prev_cnt + bmbn_pkg::CNT_W'(rcnt_new)};
		div_start = 1'b0;
		div_n     = N_W'(qx_q);
		div_d     = D_W'(ew);
		case (state_q)
			bmbn_pkg::S_IDLE:  in_ready = 1'b1;
			bmbn_pkg::S_LD_RD: begin
				ram_re    = 1'b1;
				ram_raddr = ld_addr_q;
			end
			bmbn_pkg::S_LD_WR:  ram_we = 1'b1;
			bmbn_pkg::S_Q_XMOD: div_start = 1'b1;
			bmbn_pkg::S_Q_RD:   ram_re = 1'b1;
			bmbn_pkg::S_Q_MEAN: begin
				div_start = !(mean_zero || mean_sat);
				div_n     = acc_s_q;
				div_d     = acc_c_q[D_W-1:0];
			end
			bmbn_pkg::S_Q_NORM: begin
				div_start = !norm_sat;
				div_n     = N_W'(prod_q);
				div_d     = D_W'(mean_q) + D_W'(bmbn_pkg::ONE_Q88);
			end
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bmbn_pkg::S_IDLE;
			ld_col_q    <= '0;
			ld_row_q    <= '0;
			rsum_q      <= '0;
			rcnt_q      <= '0;
			k_q         <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == bmbn_pkg::S_Q_RD);
			if (state_q == bmbn_pkg::S_IDLE && in_valid &&
			    in_data.command == bmbn_pkg::CMD_START) begin
				ld_col_q <= '0;
				ld_row_q <= '0;
				rsum_q   <= '0;
				rcnt_q   <= '0;
			end
			if (state_q == bmbn_pkg::S_LD_WR) begin
				if (col_last) begin
					ld_col_q <= '0;
					ld_row_q <= ld_row_q + ROW_W'(1);
					rsum_q   <= '0;
					rcnt_q   <= '0;
				end else begin
					ld_col_q <= ld_col_q + COL_W'(1);
					rsum_q   <= rsum_new;
					rcnt_q   <= rcnt_new;
				end
			end
			if (state_q == bmbn_pkg::S_Q_SETUP) begin
				k_q <= '0;
			end else if (state_q == bmbn_pkg::S_Q_RD) begin
				k_q <= k_q + 3'd1;
			end
			if (state_q == bmbn_pkg::S_Q_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == bmbn_pkg::S_IDLE && in_valid) begin
			pix_q     <= in_data.pixel_value;
			occ_q     <= in_data.occupied;
			ld_addr_q <= ADDR_W'(ld_row_q) * ADDR_W'(STRIDE) + ADDR_W'(ld_col_q) + ADDR_W'(1);
			ld_top_q  <= (ld_row_q == '0);
			qx_q      <= in_data.query_x;
			qy_q      <= in_data.query_y;
			pt_q      <= in_data.point_value;
			xm_q      <= COL_W'(in_data.query_x);
		end
		if (state_q == bmbn_pkg::S_Q_XWAIT && !div_busy) begin
			xm_q <= div_r[COL_W-1:0];
		end
		if (state_q == bmbn_pkg::S_Q_SETUP) begin
			y0_q <= ROW_W'(y_lo);
			y1_q <= ROW_W'(y_hi);
			if (x_full) begin
				xa0_q   <= '0;
				xa1_q   <= ew;
				xb1_q   <= '0;
				has_b_q <= 1'b0;
			end else begin
				xa0_q   <= COL_W'(x_start);
				xa1_q   <= (x_end < x_w) ? COL_W'(x_end) : ew;
				xb1_q   <= COL_W'(x_end - x_w);
				has_b_q <= (x_end > x_w);
			end
			acc_s_q <= '0;
			acc_c_q <= '0;
		end
		if (state_q == bmbn_pkg::S_Q_RD) begin
			rd_neg_s1  <= k_q[1] ^ k_q[0];
			rd_zero_s1 <= (c_row == '0) || (c_col == '0);
		end
		if (rd_vld_s1 && !rd_zero_s1) begin
			if (rd_neg_s1) begin
				acc_s_q <= acc_s_q - N_W'(rd_sum);
				acc_c_q <= acc_c_q - (D_W + 1)'(rd_cnt);
			end else begin
				acc_s_q <= acc_s_q + N_W'(rd_sum);
				acc_c_q <= acc_c_q + (D_W + 1)'(rd_cnt);
			end
		end
		if (state_q == bmbn_pkg::S_Q_MEAN) begin
			if (mean_zero) begin
				mean_q <= '0;
			end else if (mean_sat) begin
				mean_q <= VAL_W'(bmbn_pkg::MEAN_MAX);
			end
		end
		if (state_q == bmbn_pkg::S_Q_MWAIT && !div_busy) begin
			mean_q <= div_q;
		end
		if (state_q == bmbn_pkg::S_Q_MUL) begin
			prod_q <= PROD_W'(scale_q) * PROD_W'(pt_q);
			lim_q  <= (LIM_W'(mean_q) + LIM_W'(bmbn_pkg::ONE_Q88)) *
			          LIM_W'(bmbn_pkg::NORM_MAX + 1);
		end
		if (state_q == bmbn_pkg::S_Q_NORM && norm_sat) begin
			norm_q <= VAL_W'(bmbn_pkg::NORM_MAX);
		end
		if (state_q == bmbn_pkg::S_Q_NWAIT && !div_busy) begin
			norm_q <= div_q;
		end
		if (state_q == bmbn_pkg::S_Q_OUT && (!out_valid_q || out_ready)) begin
			out_q.normalized_value <= norm_q;
			out_q.window_mean      <= mean_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
